// ===== rtl/core/etl_pkg.sv =====
// shared types and constants for the exposure time to sensor line converter
package etl_pkg;

  // field and datapath widths
  localparam int EXPOSURE_BITS = 24;
  localparam int T_W           = 24;
  localparam int LEN_W         = 16;
  localparam int PCLK_W        = 32;
  localparam int LINES_W       = 16;
  localparam int NUM_W         = T_W + PCLK_W + 1;
  localparam int US_W          = 20;
  localparam int DEN_W         = LEN_W + US_W;
  localparam int Q_W           = LINES_W + 1;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // constants of the conversion
  localparam logic [US_W-1:0]  US_PER_SECOND = US_W'(1000000);
  localparam logic [LEN_W-1:0] FRAME_MARGIN  = LEN_W'(8);

  // saturation bound on the requested time
  localparam longint unsigned EXP_MAX_L = (64'd1 << EXPOSURE_BITS) - 64'd1;
  localparam logic [T_W-1:0] EXP_MAX =
    (EXPOSURE_BITS >= T_W) ? {T_W{1'b1}} : EXP_MAX_L[T_W-1:0];

  // register reset values
  localparam logic [LEN_W-1:0]  LINE_LENGTH_RST  = LEN_W'(2416);
  localparam logic [LEN_W-1:0]  FRAME_LENGTH_RST = LEN_W'(1104);
  localparam logic [PCLK_W-1:0] PIXEL_CLOCK_RST  = PCLK_W'(80017920);
  localparam logic [T_W-1:0]    MIN_EXPOSURE_RST = T_W'(1);

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_LENGTH  = 3'd0,
    CFG_FRAME_LENGTH = 3'd1,
    CFG_PIXEL_CLOCK  = 3'd2,
    CFG_MIN_EXPOSURE = 3'd3
  } cfg_idx_t;

  // payload handed from one division cell to the next
  typedef struct packed {
    logic             ovf;
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   quo;
  } div_t;

endpackage

// ===== rtl/core/etl_div_cell.sv =====
// one restoring division cell: resolves a single quotient bit per item
module etl_div_cell #(
  parameter int BIT = 0
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       valid_i,
  input  etl_pkg::div_t              data_i,
  input  logic [etl_pkg::DEN_W-1:0]  den_i,
  output logic                       valid_o,
  output etl_pkg::div_t              data_o
);

  logic [etl_pkg::NUM_W-1:0] dsh;
  logic                      ge;
  logic                      valid_r;
  etl_pkg::div_t             data_r;
  etl_pkg::div_t             data_nxt;

  // trial subtract of the shifted divisor
  always_comb begin
    dsh      = etl_pkg::NUM_W'(den_i) << BIT;
    ge       = (data_i.rem >= dsh);
    data_nxt = data_i;
    if (ge) begin
      data_nxt.rem = data_i.rem - dsh;
    end
    data_nxt.quo[BIT] = ge;
  end

  // valid flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid_o = valid_r;
  assign data_o  = data_r;

  // remainder left below the divisor at this weight when not saturated
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !data_r.ovf |-> data_r.rem < (etl_pkg::NUM_W'(den_i) << BIT))
    else $error("remainder not reduced below shifted divisor");

  // a quotient bit is never set on a remainder that was too small
  a_bit_set: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i && (data_i.rem < dsh) |=> !data_r.quo[BIT])
    else $error("quotient bit set without subtraction");

  // the chain keeps its flow: one in, one out in the next cycle
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    valid_i |=> valid_o)
    else $error("division cell dropped a transaction");

endmodule

// ===== rtl/core/exposure_time_to_sensor_lines.sv =====
// top level: exposure time in microseconds to sensor line count and register bytes
//
// One transaction is taken in every clock cycle (busy stays low), and results cannot
// be stalled: out_strobe is high for a single cycle with each result. A transaction
// passes a clamp stage, a 24x32 multiply stage and a rounding/overflow stage, then a
// chain of 17 division cells, each resolving one bit of the rounded line count, with
// one output register at the end. Configuration writes are always ready; write them
// only while no transaction is in flight.
module exposure_time_to_sensor_lines (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [etl_pkg::T_W-1:0]         in_exposure_us,
  output logic                            out_strobe,
  output logic [etl_pkg::LINES_W-1:0]     out_exposure_lines,
  output logic [3:0]                      out_reg_high_nibble,
  output logic [7:0]                      out_reg_mid_byte,
  output logic [7:0]                      out_reg_low_byte,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [etl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [etl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int LATENCY = etl_pkg::Q_W + 4;

  // configuration registers
  logic [etl_pkg::LEN_W-1:0]  line_length_r;
  logic [etl_pkg::LEN_W-1:0]  frame_length_r;
  logic [etl_pkg::PCLK_W-1:0] pixel_clock_r;
  logic [etl_pkg::T_W-1:0]    min_exposure_r;

  // derived timing values
  logic [etl_pkg::LEN_W-1:0]  hts;
  logic [etl_pkg::DEN_W-1:0]  den_r;
  logic [etl_pkg::LEN_W-1:0]  limit_r;
  logic [etl_pkg::LEN_W-1:0]  limit_nxt;

  // front stages
  logic                       accept;
  logic [etl_pkg::T_W-1:0]    t_clamp;
  logic                       s1_valid_r;
  logic [etl_pkg::T_W-1:0]    t_r;
  logic                       s2_valid_r;
  logic [etl_pkg::NUM_W-1:0]  prod_r;
  logic [etl_pkg::NUM_W-1:0]  sum;
  logic                       s3_valid_r;
  etl_pkg::div_t              s3_data_r;
  etl_pkg::div_t              s3_data_nxt;

  // division chain
  logic                       chain_valid [etl_pkg::Q_W+1];
  etl_pkg::div_t              chain_data  [etl_pkg::Q_W+1];

  // output stage
  logic [etl_pkg::Q_W-1:0]     q_sat;
  logic [etl_pkg::LINES_W-1:0] lines_nxt;
  logic [etl_pkg::LINES_W-1:0] lines_r;
  logic                        out_valid_r;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_length_r  <= etl_pkg::LINE_LENGTH_RST;
      frame_length_r <= etl_pkg::FRAME_LENGTH_RST;
      pixel_clock_r  <= etl_pkg::PIXEL_CLOCK_RST;
      min_exposure_r <= etl_pkg::MIN_EXPOSURE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        etl_pkg::CFG_LINE_LENGTH:  line_length_r  <= cfg_data[etl_pkg::LEN_W-1:0];
        etl_pkg::CFG_FRAME_LENGTH: frame_length_r <= cfg_data[etl_pkg::LEN_W-1:0];
        etl_pkg::CFG_PIXEL_CLOCK:  pixel_clock_r  <= cfg_data[etl_pkg::PCLK_W-1:0];
        etl_pkg::CFG_MIN_EXPOSURE: min_exposure_r <= cfg_data[etl_pkg::T_W-1:0];
        default: ;
      endcase
    end
  end

  // divisor and upper line limit, refreshed from the registers
  always_comb begin
    hts = (line_length_r == '0) ? etl_pkg::LEN_W'(1) : line_length_r;
    if (frame_length_r > etl_pkg::FRAME_MARGIN) begin
      limit_nxt = frame_length_r - etl_pkg::FRAME_MARGIN;
    end else begin
      limit_nxt = etl_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    den_r   <= etl_pkg::DEN_W'(hts) * etl_pkg::DEN_W'(etl_pkg::US_PER_SECOND);
    limit_r <= limit_nxt;
  end

  // raise to the minimum, then saturate at the maximum
  always_comb begin
    t_clamp = (in_exposure_us < min_exposure_r) ? min_exposure_r : in_exposure_us;
    if (t_clamp > etl_pkg::EXP_MAX) begin
      t_clamp = etl_pkg::EXP_MAX;
    end
  end

  // rounding offset and overflow check ahead of the division chain
  always_comb begin
    sum             = prod_r + etl_pkg::NUM_W'(den_r >> 1);
    s3_data_nxt.rem = sum;
    s3_data_nxt.quo = '0;
    s3_data_nxt.ovf = (sum[etl_pkg::NUM_W-1:etl_pkg::Q_W] >=
                       (etl_pkg::NUM_W-etl_pkg::Q_W)'(den_r));
  end

  // front pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  // front pipeline payload
  always_ff @(posedge clk) begin
    t_r       <= t_clamp;
    prod_r    <= etl_pkg::NUM_W'(t_r) * etl_pkg::NUM_W'(pixel_clock_r);
    s3_data_r <= s3_data_nxt;
  end

  assign chain_valid[0] = s3_valid_r;
  assign chain_data[0]  = s3_data_r;

  // one cell per quotient bit, most significant first
  for (genvar i = 0; i < etl_pkg::Q_W; i++) begin : g_cell
    etl_div_cell #(
      .BIT (etl_pkg::Q_W - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (chain_valid[i]),
      .data_i  (chain_data[i]),
      .den_i   (den_r),
      .valid_o (chain_valid[i+1]),
      .data_o  (chain_data[i+1])
    );
  end

  // saturate, force at least one line, limit to the frame
  always_comb begin
    q_sat = chain_data[etl_pkg::Q_W].ovf ? {etl_pkg::Q_W{1'b1}}
                                         : chain_data[etl_pkg::Q_W].quo;
    if (q_sat == '0) begin
      q_sat = etl_pkg::Q_W'(1);
    end
    if (q_sat > etl_pkg::Q_W'(limit_r)) begin
      lines_nxt = limit_r;
    end else begin
      lines_nxt = q_sat[etl_pkg::LINES_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= chain_valid[etl_pkg::Q_W];
    end
  end

  always_ff @(posedge clk) begin
    lines_r <= lines_nxt;
  end

  assign out_strobe          = out_valid_r;
  assign out_exposure_lines  = lines_r;
  assign out_reg_high_nibble = lines_r[15:12];
  assign out_reg_mid_byte    = lines_r[11:4];
  assign out_reg_low_byte    = {lines_r[3:0], 4'h0};

  // every accepted transaction produces its result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("result missing at expected latency");

  // a result never appears without a matching transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result without a transaction");

  // line count stays within one and the frame limit
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_exposure_lines != '0) && (out_exposure_lines <= limit_r))
    else $error("line count out of range");

endmodule
